// ===== rtl/core/bad_char_skip_line_matcher_top_macros.svh =====
// Assertion macros shared by the line matcher RTL.
// Each macro expects signals clk and rst_n in the scope where it is used.
`ifndef BAD_CHAR_SKIP_LINE_MATCHER_TOP_MACROS_SVH
`define BAD_CHAR_SKIP_LINE_MATCHER_TOP_MACROS_SVH

// Same-cycle implication, checked out of reset
`define BCSLM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset
`define BCSLM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/bcslm_pkg.sv =====
// Package for the bad-character skip line matcher.
// Holds sizes, register indexes, word and command types and the case fold.
// No dependencies.
package bcslm_pkg;

  localparam int MAX_LINE    = 1024;
  localparam int MAX_PATTERN = 32;
  localparam int REG_W       = 64;
  localparam int LINE_AW     = $clog2(MAX_LINE);
  localparam int LEN_W       = $clog2(MAX_LINE + 1);
  localparam int PLEN_W      = 6;
  localparam int PIDX_W      = $clog2(MAX_PATTERN);
  localparam int PAT_BITS    = MAX_PATTERN * 8;
  localparam int PAT_WORDS   = PAT_BITS / REG_W;
  localparam int PWSEL_W     = $clog2(PAT_WORDS);
  localparam int CNT_W       = 11;
  localparam int CFG_IDX_W   = 3;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PAT0  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PAT1  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PAT2  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PAT3  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PLEN  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_ICASE = 3'd5;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       has_byte;
    logic       end_of_line;
  } in_word_t;

  typedef struct packed {
    logic             line_matched;
    logic [CNT_W-1:0] occurrence_count;
    logic             line_truncated;
  } out_word_t;

  // Controller to datapath commands
  typedef struct packed {
    logic take;       // store the accepted input word
    logic init;       // window to zero, count to zero
    logic start_win;  // j to m-1, read text at s+m-1
    logic step_j;     // j down by one, read text at s+j-1
    logic read_next;  // read text at s+m
    logic capt_hit;   // capture last-position hits of the read byte
    logic base_is_m;  // shift base is m instead of j
    logic do_shift;   // advance window by the bad-character shift
    logic inc_s1;     // advance window by one
    logic count_inc;  // count one occurrence
    logic finish;     // load result, clear line state
  } ctl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic eq;          // read byte equals pattern byte j
    logic j_zero;      // j is at the first pattern byte
    logic more_after;  // a byte follows the window
    logic in_range;    // window fits in the line
  } dp_stat_t;

  // Fold ASCII upper case to lower case when enabled
  function automatic logic [7:0] fold_byte(input logic [7:0] b, input logic fold);
    logic [7:0] r;
    r = b;
    if (fold && (b inside {[8'h41:8'h5A]})) begin
      r = b + 8'h20;
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/bad_char_skip_line_matcher_top.sv =====
// Top level of the bad-character skip line matcher.
// Depends on bcslm_pkg, bcslm_ctrl and bcslm_dp.
//
//   channel   dir   handshake           payload
//   in_       in    in_valid/in_ready   in_word   (in_word_t)
//   out_      out   out_valid/out_ready out_word  (out_word_t)
//   cfg_      in    cfg_we              cfg_index, cfg_data
//
// Each accepted text byte is written to the line buffer. At line end the
// search prepares, then for each window tried checks the bound, compares
// bytes from the right through the single read port and advances the window.
// Reset is synchronous on rst_n; the line buffer is not cleared.
// No input is taken while a search runs; a finished word waits in the
// output register and the next line loads meanwhile.
module bad_char_skip_line_matcher_top import bcslm_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_word_t             in_word,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_word_t            out_word,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [REG_W-1:0]     cfg_data
);

  ctl_cmd_t cmd;
  dp_stat_t stat;

  // Sequencer
  bcslm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_eol    (in_word.end_of_line),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Buffer, compare and shift
  bcslm_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_word   (in_word),
    .cmd       (cmd),
    .stat      (stat),
    .out_word  (out_word)
  );

endmodule

// ===== rtl/core/bcslm_ctrl.sv =====
// Controller for the line matcher: load, search and result hand-off sequence.
// Depends on bcslm_pkg and the shared assertion macros.
`include "bad_char_skip_line_matcher_top_macros.svh"

module bcslm_ctrl import bcslm_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_eol,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  dp_stat_t stat,
  output ctl_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_LOAD,
    S_PREP,
    S_CHK,
    S_CMP,
    S_NEXT,
    S_SHIFT,
    S_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  // Next state and commands
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    case (state_r)
      S_LOAD: begin
        if (in_valid) begin
          cmd.take = 1'b1;
          if (in_eol) begin
            state_nxt = S_PREP;
          end
        end
      end
      S_PREP: begin
        cmd.init  = 1'b1;
        state_nxt = S_CHK;
      end
      S_CHK: begin
        if (stat.in_range) begin
          cmd.start_win = 1'b1;
          state_nxt     = S_CMP;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_CMP: begin
        cmd.capt_hit = 1'b1;
        if (stat.eq) begin
          if (!stat.j_zero) begin
            cmd.step_j = 1'b1;
          end else begin
            cmd.count_inc = 1'b1;
            if (stat.more_after) begin
              cmd.read_next = 1'b1;
              state_nxt     = S_NEXT;
            end else begin
              cmd.inc_s1 = 1'b1;
              state_nxt  = S_CHK;
            end
          end
        end else begin
          state_nxt = S_SHIFT;
        end
      end
      S_NEXT: begin
        cmd.capt_hit  = 1'b1;
        cmd.base_is_m = 1'b1;
        state_nxt     = S_SHIFT;
      end
      S_SHIFT: begin
        cmd.do_shift = 1'b1;
        state_nxt    = S_CHK;
      end
      S_DONE: begin
        // hold until the output register is free
        if (!out_valid_r || out_ready) begin
          cmd.finish    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_LOAD;
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_LOAD);
  assign out_valid = out_valid_r;

  `BCSLM_ASSERT_NEXT(a_finish_shows_word, cmd.finish, out_valid_r, "result not presented")
  `BCSLM_ASSERT_NEXT(a_wait_holds, (state_r == S_DONE) && out_valid_r && !out_ready, (state_r == S_DONE), "waiting word overrun")
  `BCSLM_ASSERT_NEXT(a_eol_starts_search, in_valid && in_ready && in_eol, (state_r == S_PREP), "line end did not start search")

endmodule

// ===== rtl/core/bcslm_dp.sv =====
// Datapath for the line matcher: config registers, line buffer, window
// position, compare, last-position lookup, shift and count.
// Depends on bcslm_pkg and the shared assertion macros.
`include "bad_char_skip_line_matcher_top_macros.svh"

module bcslm_dp import bcslm_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [REG_W-1:0]     cfg_data,
  input  in_word_t             in_word,
  input  ctl_cmd_t             cmd,
  output dp_stat_t             stat,
  output out_word_t            out_word
);

  logic [PAT_BITS-1:0]    pat_r;
  logic [PLEN_W-1:0]      plen_r;
  logic                   icase_r;
  logic [LEN_W-1:0]       len_r;
  logic                   trunc_r;
  logic [LEN_W-1:0]       s_r;
  logic [PIDX_W-1:0]      j_r;
  logic [CNT_W-1:0]       cnt_r;
  logic [MAX_PATTERN-1:0] hit_r, hit_nxt;
  logic [PLEN_W-1:0]      base_r;
  logic [7:0]             rd_r;
  out_word_t              res_r;

  logic [7:0]   line_mem [MAX_LINE];

  logic [PLEN_W-1:0]  m_eff;
  logic [7:0]         pat_f [MAX_PATTERN];
  logic [7:0]         txt_f;
  logic [PLEN_W-1:0]  lp1;
  logic [PLEN_W:0]    diff;
  logic [PLEN_W-1:0]  shift;
  logic [LEN_W:0]     s_pm;
  logic [LEN_W-1:0]   rd_sum;
  logic               rd_en;
  logic               wr_en;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_r   <= '0;
      plen_r  <= PLEN_W'(1);
      icase_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PAT0, CFG_PAT1, CFG_PAT2, CFG_PAT3: begin
          pat_r[cfg_index[PWSEL_W-1:0]*REG_W +: REG_W] <= cfg_data;
        end
        CFG_PLEN: begin
          plen_r <= cfg_data[PLEN_W-1:0];
        end
        CFG_ICASE: begin
          icase_r <= cfg_data[0];
        end
        default: begin
        end
      endcase
    end
  end

  // Clamp pattern length to 1..MAX_PATTERN
  always_comb begin
    if (plen_r == '0) begin
      m_eff = PLEN_W'(1);
    end else if (plen_r > PLEN_W'(MAX_PATTERN)) begin
      m_eff = PLEN_W'(MAX_PATTERN);
    end else begin
      m_eff = plen_r;
    end
  end

  // Folded pattern bytes
  genvar g;
  for (g = 0; g < MAX_PATTERN; g++) begin : g_fold
    assign pat_f[g] = fold_byte(pat_r[g*8 +: 8], icase_r);
  end

  assign txt_f = fold_byte(rd_r, icase_r);

  // Hit vector: pattern positions holding the read byte, below m
  always_comb begin
    for (int k = 0; k < MAX_PATTERN; k++) begin
      hit_nxt[k] = (pat_f[k] == txt_f) && (PLEN_W'(k) < m_eff);
    end
  end

  // Last position plus one from the captured hits, zero when absent
  always_comb begin
    lp1 = '0;
    for (int k = 0; k < MAX_PATTERN; k++) begin
      if (hit_r[k]) begin
        lp1 = PLEN_W'(k + 1);
      end
    end
  end

  // Bad-character shift, at least one
  assign diff  = {1'b0, base_r} + (PLEN_W+1)'(1) - {1'b0, lp1};
  assign shift = (diff[PLEN_W] || (diff == '0)) ? PLEN_W'(1) : diff[PLEN_W-1:0];

  // Window bounds
  assign s_pm = {1'b0, s_r} + (LEN_W+1)'(m_eff);

  assign stat.eq         = (txt_f == pat_f[j_r]);
  assign stat.j_zero     = (j_r == '0);
  assign stat.more_after = (s_pm < {1'b0, len_r});
  assign stat.in_range   = (s_pm <= {1'b0, len_r});

  // Buffer read address
  always_comb begin
    rd_sum = s_r + LEN_W'(m_eff);
    if (cmd.start_win) begin
      rd_sum = s_r + LEN_W'(m_eff) - LEN_W'(1);
    end else if (cmd.step_j) begin
      rd_sum = s_r + LEN_W'(j_r) - LEN_W'(1);
    end
  end

  assign rd_en = cmd.start_win || cmd.step_j || cmd.read_next;
  assign wr_en = cmd.take && in_word.has_byte && (len_r < LEN_W'(MAX_LINE));

  // Line buffer
  always_ff @(posedge clk) begin
    if (wr_en) begin
      line_mem[len_r[LINE_AW-1:0]] <= in_word.text_byte;
    end
    if (rd_en) begin
      rd_r <= line_mem[rd_sum[LINE_AW-1:0]];
    end
  end

  // Line length and overflow flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r   <= '0;
      trunc_r <= 1'b0;
    end else if (cmd.finish) begin
      len_r   <= '0;
      trunc_r <= 1'b0;
    end else if (cmd.take && in_word.has_byte) begin
      if (len_r < LEN_W'(MAX_LINE)) begin
        len_r <= len_r + LEN_W'(1);
      end else begin
        trunc_r <= 1'b1;
      end
    end
  end

  // Window position, pattern index, count and hits
  always_ff @(posedge clk) begin
    if (cmd.init) begin
      s_r <= '0;
    end else if (cmd.do_shift) begin
      s_r <= s_r + LEN_W'(shift);
    end else if (cmd.inc_s1) begin
      s_r <= s_r + LEN_W'(1);
    end

    if (cmd.start_win) begin
      j_r <= PIDX_W'(m_eff - PLEN_W'(1));
    end else if (cmd.step_j) begin
      j_r <= j_r - PIDX_W'(1);
    end

    if (cmd.init) begin
      cnt_r <= '0;
    end else if (cmd.count_inc && (cnt_r != CNT_MAX)) begin
      cnt_r <= cnt_r + CNT_W'(1);
    end

    if (cmd.capt_hit) begin
      hit_r  <= hit_nxt;
      base_r <= cmd.base_is_m ? m_eff : PLEN_W'(j_r);
    end

    if (cmd.finish) begin
      res_r.line_matched     <= (cnt_r != '0);
      res_r.occurrence_count <= cnt_r;
      res_r.line_truncated   <= trunc_r;
    end
  end

  assign out_word = res_r;

  `BCSLM_ASSERT_NEXT(a_finish_clears_line, cmd.finish, (len_r == '0) && !trunc_r, "line state not cleared")
  `BCSLM_ASSERT_NOW(a_len_bound, 1'b1, len_r <= LEN_W'(MAX_LINE), "line length beyond buffer")
  `BCSLM_ASSERT_NEXT(a_count_moves, cmd.count_inc, cnt_r != '0, "occurrence not counted")

endmodule
